### rtl/rvcore_pkg.sv
// ============================================================================
// rvcore_pkg: shared types and constants of the RV32I subset core
// Holds the instruction encodings, the data memory geometry and the
// result record that passes from the execute logic to the top level.
// ============================================================================
package rvcore_pkg;

    // Data memory geometry. The byte store is split into four byte lanes.
    localparam int DMEM_BYTES = 4096;
    localparam int DMEM_AW    = $clog2(DMEM_BYTES);
    localparam int DMEM_ROWS  = DMEM_BYTES / 4;
    localparam int ROW_AW     = DMEM_AW - 2;

    // Register file geometry.
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = 5;

    // Opcodes.
    localparam logic [6:0] OPC_LOAD = 7'h03;
    localparam logic [6:0] OPC_ALUI = 7'h13;
    localparam logic [6:0] OPC_STORE = 7'h23;
    localparam logic [6:0] OPC_ALU  = 7'h33;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR = 7'h67;

    // Function codes.
    localparam logic [2:0] F3_ADD = 3'h0;
    localparam logic [2:0] F3_XOR = 3'h4;
    localparam logic [2:0] F3_SRA = 3'h5;
    localparam logic [2:0] F3_AND = 3'h7;
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Architectural registers that are reported on every result beat.
    localparam logic [RF_AW-1:0] A0_IDX = 5'd10;
    localparam logic [RF_AW-1:0] A1_IDX = 5'd11;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        illegal;
        logic        branch_taken;
        logic        wb_valid;
        logic [4:0]  wb_index;
        logic [31:0] wb_value;
        logic        store_valid;
        logic [11:0] store_address;
        logic [31:0] store_value;
        logic [31:0] a0_value;
        logic [31:0] a1_value;
    } t_res;

    typedef struct packed {
        t_res               res;
        logic               load;
        logic [DMEM_AW-1:0] maddr;
    } t_exec;

endpackage

### rtl/rv32_subset_single_cycle_core_unit.sv
// ============================================================================
// rv32_subset_single_cycle_core_unit: RV32I subset core, one instruction a beat
// Executes ADD, SUB, XOR, SRA, ADDI, ANDI, LW, SW, BLT and JALR on an
// instruction stream and reports the architectural effect of each one.
// ============================================================================
//
// Each input beat carries the instruction word fetched at the current PC and
// produces exactly one result beat: the next PC, the illegal flag, the branch
// decision, the register write, the store, and x10/x11 after the instruction.
// The register file lives in two synchronous RAMs (one per source operand)
// and the data memory in four byte-lane RAMs, all with registered reads.
// An instruction is read from the register file in the cycle it is accepted
// and executes in the following cycle; a register write that lands in the
// same edge as the read is forwarded. Arithmetic, branch, jump and store
// instructions sustain one beat per cycle while the output keeps up; a load
// waits in the completion slot for its data-memory read, and no instruction
// is accepted while a load is in the execute slot. A finished result waits
// in an output register, so the next instruction is accepted while the
// previous result is still pending, provided the execute slot is empty or
// the output register empties in the same cycle. After reset the core
// clears its data memory, one word row per cycle, all DMEM_BYTES/4 rows
// (1024 with 4096 bytes); no instruction is accepted during that pass.
// Word accesses may be unaligned and wrap around the end of the data memory.
//
module rv32_subset_single_cycle_core_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_instruction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_next_pc,
    output logic        o_illegal,
    output logic        o_branch_taken,
    output logic        o_wb_valid,
    output logic [4:0]  o_wb_index,
    output logic [31:0] o_wb_value,
    output logic        o_store_valid,
    output logic [11:0] o_store_address,
    output logic [31:0] o_store_value,
    output logic [31:0] o_a0_value,
    output logic [31:0] o_a1_value
);
    import rvcore_pkg::*;

    // Execute slot: the instruction whose operands come out of the RAMs.
    logic             r_d_valid;
    logic [31:0]      r_d_ins;
    // Register write that happened on the edge the operands were read.
    logic             r_fw_valid;
    logic [RF_AW-1:0] r_fw_idx;
    logic [31:0]      r_fw_data;
    // Load completion slot.
    logic             r_m_valid;
    logic [4:0]       r_m_rd;
    logic [1:0]       r_m_off;
    logic [31:0]      r_m_pc;
    // Output register.
    logic             r_o_valid;
    t_res             r_out;
    // Architectural state kept in flops.
    logic [31:0]         r_pc;
    logic [31:0]         r_x10;
    logic [31:0]         r_x11;
    logic [RF_DEPTH-1:0] r_rf_vld;
    // Data memory clearing pass.
    logic                r_clr_busy;
    logic [ROW_AW-1:0]   r_clr_row;

    logic        accept;
    logic        out_free;
    logic        m_adv;
    logic        d_adv;
    logic        commit;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] q1;
    logic [31:0] q2;
    logic [31:0] op_a;
    logic [31:0] op_b;
    t_exec       ex;
    t_res        n_out;
    logic [31:0] ld_val;
    logic        rf_we;
    logic [1:0]  off;
    logic [ROW_AW-1:0] row;

    logic              lane_we    [4];
    logic [ROW_AW-1:0] lane_addr  [4];
    logic [7:0]        lane_wdata [4];
    logic [7:0]        lane_q     [4];

    // ------------------------------------------------------------------
    // Handshake and slot movement. A load moves into the completion slot
    // and holds back the next instruction until its data is written.
    // ------------------------------------------------------------------
    assign out_free = !r_o_valid || i_out_ready;
    assign m_adv    = r_m_valid && out_free;
    assign d_adv    = r_d_valid && (ex.load ? !r_m_valid : out_free);
    assign commit   = m_adv || (d_adv && !ex.load);

    assign o_in_ready = !r_clr_busy && (!r_m_valid || m_adv)
                        && (!r_d_valid || (d_adv && !ex.load));
    assign accept     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Register file: two copies so that both sources are read in the same cycle.
    // Entries that were never written read as zero through the valid bits.
    // ------------------------------------------------------------------
    assign rs1 = r_d_ins[19:15];
    assign rs2 = r_d_ins[24:20];

    rvcore_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (n_out.wb_index),
        .i_wdata (n_out.wb_value),
        .i_re    (accept),
        .i_raddr (i_instruction[19:15]),
        .o_rdata (q1)
    );

    rvcore_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (n_out.wb_index),
        .i_wdata (n_out.wb_value),
        .i_re    (accept),
        .i_raddr (i_instruction[24:20]),
        .o_rdata (q2)
    );

    assign op_a = (r_fw_valid && r_fw_idx == rs1) ? r_fw_data
                : (r_rf_vld[rs1] ? q1 : '0);
    assign op_b = (r_fw_valid && r_fw_idx == rs2) ? r_fw_data
                : (r_rf_vld[rs2] ? q2 : '0);

    rvcore_exec u_exec (
        .i_ins (r_d_ins),
        .i_pc  (r_pc),
        .i_a   (op_a),
        .i_b   (op_b),
        .o_ex  (ex)
    );

    // ------------------------------------------------------------------
    // Data memory: byte lane j holds the bytes whose address ends in j.
    // A word starting at offset off takes the next row in the lanes below
    // off, which also covers the wrap at the end of the memory.
    // ------------------------------------------------------------------
    assign off = ex.maddr[1:0];
    assign row = ex.maddr[DMEM_AW-1:2];

    always_comb begin
        logic [1:0] k;
        for (int j = 0; j < 4; j++) begin
            k = 2'(j) - off;
            if (r_clr_busy) begin
                lane_we[j]    = 1'b1;
                lane_addr[j]  = r_clr_row;
                lane_wdata[j] = '0;
            end else begin
                lane_we[j]    = d_adv && ex.res.store_valid;
                lane_addr[j]  = row + ROW_AW'(2'(j) < off);
                lane_wdata[j] = ex.res.store_value[{k, 3'b000} +: 8];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        rvcore_ram #(.WIDTH(8), .DEPTH(DMEM_ROWS)) u_dmem (
            .i_clk   (i_clk),
            .i_we    (lane_we[g]),
            .i_waddr (lane_addr[g]),
            .i_wdata (lane_wdata[g]),
            .i_re    (d_adv && ex.load),
            .i_raddr (lane_addr[g]),
            .o_rdata (lane_q[g])
        );
    end

    // Reassemble the loaded word from the lanes, lowest address first.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ld_val[8*k +: 8] = lane_q[2'(r_m_off + 2'(k))];
        end
    end

    // ------------------------------------------------------------------
    // Result of the instruction that completes this cycle: a finished load
    // from the completion slot, or anything else straight from execute.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_m_valid) begin
            n_out          = '0;
            n_out.next_pc  = r_m_pc;
            n_out.wb_valid = r_m_rd != '0;
            n_out.wb_index = r_m_rd;
            n_out.wb_value = ld_val;
        end else begin
            n_out = ex.res;
        end
        n_out.a0_value = (n_out.wb_valid && n_out.wb_index == A0_IDX) ? n_out.wb_value
                                                                       : r_x10;
        n_out.a1_value = (n_out.wb_valid && n_out.wb_index == A1_IDX) ? n_out.wb_value
                                                                       : r_x11;
    end

    assign rf_we = commit && n_out.wb_valid;

    // ------------------------------------------------------------------
    // Control and state registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
            r_m_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_pc       <= '0;
            r_x10      <= '0;
            r_x11      <= '0;
            r_rf_vld   <= '0;
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (accept) begin
                r_d_valid  <= 1'b1;
                r_fw_valid <= rf_we;
            end else if (d_adv) begin
                r_d_valid <= 1'b0;
            end

            if (d_adv && ex.load) begin
                r_m_valid <= 1'b1;
            end else if (m_adv) begin
                r_m_valid <= 1'b0;
            end

            if (d_adv) begin
                r_pc <= ex.res.next_pc;
            end

            if (commit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            if (rf_we) begin
                r_rf_vld[n_out.wb_index] <= 1'b1;
                if (n_out.wb_index == A0_IDX) begin
                    r_x10 <= n_out.wb_value;
                end
                if (n_out.wb_index == A1_IDX) begin
                    r_x11 <= n_out.wb_value;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_d_ins   <= i_instruction;
            r_fw_idx  <= n_out.wb_index;
            r_fw_data <= n_out.wb_value;
        end
        if (d_adv && ex.load) begin
            r_m_rd  <= ex.res.wb_index;
            r_m_off <= off;
            r_m_pc  <= ex.res.next_pc;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_next_pc       = r_out.next_pc;
    assign o_illegal       = r_out.illegal;
    assign o_branch_taken  = r_out.branch_taken;
    assign o_wb_valid      = r_out.wb_valid;
    assign o_wb_index      = r_out.wb_index;
    assign o_wb_value      = r_out.wb_value;
    assign o_store_valid   = r_out.store_valid;
    assign o_store_address = r_out.store_address;
    assign o_store_value   = r_out.store_value;
    assign o_a0_value      = r_out.a0_value;
    assign o_a1_value      = r_out.a1_value;

endmodule

### rtl/rvcore_ram.sv
// ============================================================================
// rvcore_ram: generic synchronous RAM
// One write port and one read port on a shared clock; the read data is
// registered and returns the contents from before a same-cycle write.
// ============================================================================
module rvcore_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rvcore_exec.sv
// ============================================================================
// rvcore_exec: decode and execute of one instruction
// Works out the next PC, the register write, the store and the memory
// address from the instruction word, the PC and both source operands.
// ============================================================================
module rvcore_exec (
    input  logic [31:0]       i_ins,
    input  logic [31:0]       i_pc,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output rvcore_pkg::t_exec o_ex
);
    import rvcore_pkg::*;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] sum_i;
    logic [31:0] sum_s;
    logic [31:0] pc4;
    logic [31:0] saddr_w;
    logic        wr;
    logic [31:0] val;

    assign opc   = i_ins[6:0];
    assign f3    = i_ins[14:12];
    assign f7    = i_ins[31:25];
    assign rd    = i_ins[11:7];
    assign imm_i = {{20{i_ins[31]}}, i_ins[31:20]};
    assign imm_s = {{20{i_ins[31]}}, i_ins[31:25], i_ins[11:7]};
    assign imm_b = {{19{i_ins[31]}}, i_ins[31], i_ins[7], i_ins[30:25], i_ins[11:8], 1'b0};
    assign sum_i = i_a + imm_i;
    assign sum_s = i_a + imm_s;
    assign pc4   = i_pc + 32'd4;
    assign saddr_w = 32'(sum_s[DMEM_AW-1:0]);

    always_comb begin
        o_ex            = '0;
        o_ex.res.next_pc = pc4;
        o_ex.maddr      = sum_i[DMEM_AW-1:0];
        wr              = 1'b0;
        val             = '0;
        unique case (opc)
            OPC_ALU: begin
                wr = 1'b1;
                if (f7 == F7_BASE && f3 == F3_ADD) begin
                    val = i_a + i_b;
                end else if (f7 == F7_BASE && f3 == F3_XOR) begin
                    val = i_a ^ i_b;
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    val = i_a - i_b;
                end else if (f7 == F7_ALT && f3 == F3_SRA) begin
                    val = $unsigned($signed(i_a) >>> i_b[4:0]);
                end else begin
                    wr               = 1'b0;
                    o_ex.res.illegal = 1'b1;
                end
            end
            OPC_ALUI: begin
                wr = 1'b1;
                if (f3 == F3_ADD) begin
                    val = sum_i;
                end else if (f3 == F3_AND) begin
                    val = i_a & imm_i;
                end else begin
                    wr               = 1'b0;
                    o_ex.res.illegal = 1'b1;
                end
            end
            OPC_LOAD: begin
                // The loaded word comes from the registered data-memory read; the top level fills it in.
                wr        = 1'b1;
                o_ex.load = 1'b1;
            end
            OPC_STORE: begin
                o_ex.maddr              = sum_s[DMEM_AW-1:0];
                o_ex.res.store_valid    = 1'b1;
                o_ex.res.store_address  = saddr_w[11:0];
                o_ex.res.store_value    = i_b;
            end
            OPC_BRANCH: begin
                if ($signed(i_a) < $signed(i_b)) begin
                    o_ex.res.branch_taken = 1'b1;
                    o_ex.res.next_pc      = i_pc + imm_b;
                end
            end
            OPC_JALR: begin
                o_ex.res.next_pc = {sum_i[31:1], 1'b0};
                val              = pc4;
                wr               = 1'b1;
            end
            default: begin
                o_ex.res.illegal = 1'b1;
            end
        endcase
        // Register x0 is never written.
        if (rd == '0) begin
            wr = 1'b0;
        end
        o_ex.res.wb_valid = wr;
        o_ex.res.wb_index = wr ? rd : '0;
        o_ex.res.wb_value = wr ? val : '0;
    end

endmodule

### tb/core_result_checker.sv
// ============================================================================
// core_result_checker: result predictor and scoreboard for the RV32I core
// Watches the instruction and result channels, executes every accepted
// instruction on its own copy of the architectural state and compares each
// result beat, field by field, with the oldest prediction.
// ============================================================================
`timescale 1ns / 100ps

module core_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_instruction,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_next_pc,
    input  logic        i_illegal,
    input  logic        i_branch_taken,
    input  logic        i_wb_valid,
    input  logic [4:0]  i_wb_index,
    input  logic [31:0] i_wb_value,
    input  logic        i_store_valid,
    input  logic [11:0] i_store_address,
    input  logic [31:0] i_store_value,
    input  logic [31:0] i_a0_value,
    input  logic [31:0] i_a1_value,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import rvcore_pkg::*;

    // Architectural state as the core should hold it.
    logic [31:0] arch_pc;
    logic [31:0] arch_regs [RF_DEPTH];
    logic [7:0]  arch_dmem [DMEM_BYTES];

    t_res predicted_retires [$];
    int   fail_total;
    int   checked_total;

    function automatic int unsigned byte_addr(input logic [31:0] base, input int unsigned k);
        return (base % int'(DMEM_BYTES) + k) % int'(DMEM_BYTES);
    endfunction

    // Executes one instruction on the shadow state and returns its result beat.
    function automatic t_res retire_instruction(input logic [31:0] word);
        t_res        r;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] npc;
        logic [31:0] value;
        logic [31:0] base;
        logic        writes;

        opc    = word[6:0];
        f3     = word[14:12];
        f7     = word[31:25];
        rd     = word[11:7];
        a      = arch_regs[word[19:15]];
        b      = arch_regs[word[24:20]];
        imm_i  = {{20{word[31]}}, word[31:20]};
        imm_s  = {{20{word[31]}}, word[31:25], word[11:7]};
        imm_b  = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
        r      = '0;
        npc    = arch_pc + 32'd4;
        value  = '0;
        writes = 1'b0;

        case (opc)
            OPC_ALU: begin
                writes = 1'b1;
                if (f7 == F7_BASE && f3 == F3_ADD) begin
                    value = a + b;
                end else if (f7 == F7_BASE && f3 == F3_XOR) begin
                    value = a ^ b;
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    value = a - b;
                end else if (f7 == F7_ALT && f3 == F3_SRA) begin
                    value = $signed(a) >>> b[4:0];
                end else begin
                    r.illegal = 1'b1;
                    writes    = 1'b0;
                end
            end
            OPC_ALUI: begin
                writes = 1'b1;
                if (f3 == F3_ADD) begin
                    value = a + imm_i;
                end else if (f3 == F3_AND) begin
                    value = a & imm_i;
                end else begin
                    r.illegal = 1'b1;
                    writes    = 1'b0;
                end
            end
            OPC_LOAD: begin
                base = a + imm_i;
                for (int k = 0; k < 4; k++) begin
                    value[8*k +: 8] = arch_dmem[byte_addr(base, k)];
                end
                writes = 1'b1;
            end
            OPC_STORE: begin
                base = a + imm_s;
                for (int k = 0; k < 4; k++) begin
                    arch_dmem[byte_addr(base, k)] = b[8*k +: 8];
                end
                r.store_valid   = 1'b1;
                r.store_address = 12'(byte_addr(base, 0));
                r.store_value   = b;
            end
            OPC_BRANCH: begin
                if ($signed(a) < $signed(b)) begin
                    r.branch_taken = 1'b1;
                    npc            = arch_pc + imm_b;
                end
            end
            OPC_JALR: begin
                npc    = (a + imm_i) & ~32'd1;
                value  = arch_pc + 32'd4;
                writes = 1'b1;
            end
            default: begin
                r.illegal = 1'b1;
            end
        endcase

        if (rd == '0) begin
            writes = 1'b0;
        end
        if (writes) begin
            arch_regs[rd] = value;
            r.wb_valid    = 1'b1;
            r.wb_index    = rd;
            r.wb_value    = value;
        end
        arch_pc    = npc;
        r.next_pc  = npc;
        r.a0_value = arch_regs[A0_IDX];
        r.a1_value = arch_regs[A1_IDX];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;

        if (!i_rst_n) begin
            arch_pc = '0;
            for (int i = 0; i < RF_DEPTH; i++) begin
                arch_regs[i] = '0;
            end
            for (int i = 0; i < DMEM_BYTES; i++) begin
                arch_dmem[i] = '0;
            end
            predicted_retires.delete();
            fail_total    = 0;
            checked_total = 0;
        end else begin
            // A result always belongs to an instruction accepted at an earlier
            // edge, so the comparison comes before this edge's prediction.
            if (i_out_valid && i_out_ready) begin
                if (predicted_retires.size() == 0) begin
                    $error("Result beat with no instruction outstanding, next_pc %h",
                           i_next_pc);
                    fail_total++;
                end else begin
                    want = predicted_retires.pop_front();
                    compare_field("next_pc", want.next_pc, i_next_pc);
                    compare_field("illegal", want.illegal, i_illegal);
                    compare_field("branch_taken", want.branch_taken, i_branch_taken);
                    compare_field("wb_valid", want.wb_valid, i_wb_valid);
                    compare_field("wb_index", want.wb_index, i_wb_index);
                    compare_field("wb_value", want.wb_value, i_wb_value);
                    compare_field("store_valid", want.store_valid, i_store_valid);
                    compare_field("store_address", want.store_address, i_store_address);
                    compare_field("store_value", want.store_value, i_store_value);
                    compare_field("a0_value", want.a0_value, i_a0_value);
                    compare_field("a1_value", want.a1_value, i_a1_value);
                end
                checked_total++;
            end
            if (i_in_valid && i_in_ready) begin
                predicted_retires.push_back(retire_instruction(i_instruction));
            end
        end

        o_fail_count <= fail_total;
        o_pending    <= predicted_retires.size();
        o_checked    <= checked_total;
    end

endmodule

### tb/testbench.sv
// ============================================================================
// testbench: stimulus and verdict for rv32_subset_single_cycle_core_unit
// Feeds the core a directed instruction sequence followed by a weighted
// random stream, with random idling on both channels, a quiet stretch and a
// long result back-pressure stall, and reports the checker's verdict.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
    import rvcore_pkg::*;

    // Function codes that the package does not name. The memory and branch
    // instructions ignore funct3, but the canonical encodings are used by
    // default; the odd funct7/funct3 values provoke the illegal flag.
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BAD  = 3'd1;
    localparam logic [6:0] F7_BAD  = 7'h01;

    // The receiver stall is well below the watchdog limit, and so is the
    // data-memory clearing pass after reset.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int IDLE_PERCENT   = 7;

    typedef enum int {
        OP_ADD, OP_SUB, OP_XOR, OP_SRA, OP_ADDI, OP_ANDI,
        OP_LW, OP_SW, OP_BLT, OP_JALR
    } t_op_kind;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [31:0] i_instruction = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_next_pc;
    logic        o_illegal;
    logic        o_branch_taken;
    logic        o_wb_valid;
    logic [4:0]  o_wb_index;
    logic [31:0] o_wb_value;
    logic        o_store_valid;
    logic [11:0] o_store_address;
    logic [31:0] o_store_value;
    logic [31:0] o_a0_value;
    logic [31:0] o_a1_value;

    int fail_count;
    int pending_count;
    int checked_count;

    // Phase flags shared by the sender and the receiver.
    bit quiet_phase;
    bit hold_wanted;
    bit hold_served;

    int          sent_count;
    int          directed_count;
    logic [31:0] directed_words [$];

    rv32_subset_single_cycle_core_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_instruction   (i_instruction),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_next_pc       (o_next_pc),
        .o_illegal       (o_illegal),
        .o_branch_taken  (o_branch_taken),
        .o_wb_valid      (o_wb_valid),
        .o_wb_index      (o_wb_index),
        .o_wb_value      (o_wb_value),
        .o_store_valid   (o_store_valid),
        .o_store_address (o_store_address),
        .o_store_value   (o_store_value),
        .o_a0_value      (o_a0_value),
        .o_a1_value      (o_a1_value)
    );

    core_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_instruction   (i_instruction),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_next_pc       (o_next_pc),
        .i_illegal       (o_illegal),
        .i_branch_taken  (o_branch_taken),
        .i_wb_valid      (o_wb_valid),
        .i_wb_index      (o_wb_index),
        .i_wb_value      (o_wb_value),
        .i_store_valid   (o_store_valid),
        .i_store_address (o_store_address),
        .i_store_value   (o_store_value),
        .i_a0_value      (o_a0_value),
        .i_a1_value      (o_a1_value),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count),
        .o_checked       (checked_count)
    );

    // 2 ns clock period.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Instruction encoders, one per RISC-V format the core understands.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    // The branch offset is a 13-bit byte offset; bit 0 is not encoded.
    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    // Most operands come from a small window that holds x10 and x11, so that
    // results chain into one another and the forwarding path is exercised.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 99) < 70) begin
            return 5'($urandom_range(8, 13));
        end
        return 5'($urandom_range(0, 31));
    endfunction

    // Load and store offsets against x0 cluster around address zero, so that
    // loads find earlier stores and words straddle the end of the memory.
    function automatic logic [11:0] pick_mem_offset();
        if ($urandom_range(0, 1) == 0) begin
            return 12'($urandom_range(0, 15));
        end
        return 12'hFF8 + 12'($urandom_range(0, 7));
    endfunction

    // Mostly well-formed instructions with random operands; a share of pure
    // noise words and of ALU words with scrambled function codes.
    function automatic logic [31:0] random_instruction();
        int          roll;
        t_op_kind    op;
        logic [4:0]  rs1;
        logic [2:0]  f3_any;
        logic [31:0] noise;

        roll   = $urandom_range(0, 99);
        noise  = $urandom();
        rs1    = pick_reg();
        f3_any = ($urandom_range(0, 99) < 20) ? 3'($urandom_range(0, 7)) : F3_WORD;
        if (roll < 8) begin
            return noise;
        end
        if (roll < 14) begin
            return {noise[31:7], ($urandom_range(0, 1) == 0) ? OPC_ALU : OPC_ALUI};
        end
        op = t_op_kind'($urandom_range(OP_ADD, OP_JALR));
        case (op)
            OP_ADD:  return enc_r(F7_BASE, pick_reg(), rs1, F3_ADD, pick_reg(), OPC_ALU);
            OP_SUB:  return enc_r(F7_ALT, pick_reg(), rs1, F3_ADD, pick_reg(), OPC_ALU);
            OP_XOR:  return enc_r(F7_BASE, pick_reg(), rs1, F3_XOR, pick_reg(), OPC_ALU);
            OP_SRA:  return enc_r(F7_ALT, pick_reg(), rs1, F3_SRA, pick_reg(), OPC_ALU);
            OP_ADDI: return enc_i(noise[11:0], rs1, F3_ADD, pick_reg(), OPC_ALUI);
            OP_ANDI: return enc_i(noise[11:0], rs1, F3_AND, pick_reg(), OPC_ALUI);
            OP_LW: begin
                if ($urandom_range(0, 99) < 60) begin
                    return enc_i(pick_mem_offset(), 5'd0, f3_any, pick_reg(), OPC_LOAD);
                end
                return enc_i(noise[11:0], rs1, f3_any, pick_reg(), OPC_LOAD);
            end
            OP_SW: begin
                if ($urandom_range(0, 99) < 60) begin
                    return enc_s(pick_mem_offset(), pick_reg(), 5'd0, f3_any);
                end
                return enc_s(noise[11:0], pick_reg(), rs1, f3_any);
            end
            OP_BLT: begin
                return enc_b(noise[12:0], pick_reg(), rs1,
                             (f3_any == F3_WORD) ? F3_BLT : f3_any);
            end
            default: begin
                return enc_i(noise[11:0], rs1, (f3_any == F3_WORD) ? F3_ADD : f3_any,
                             pick_reg(), OPC_JALR);
            end
        endcase
    endfunction

    // Presents one instruction beat and returns at the edge that accepts it.
    // Outside the quiet phase the sender may then idle at random.
    task automatic offer_instruction(input logic [31:0] word);
        i_in_valid    <= 1'b1;
        i_instruction <= word;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sent_count++;
        if (!quiet_phase) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver. It stalls at random outside the quiet phase, and once,
    // on request, holds ready low for a long stretch so that the core's
    // output register fills and the instruction channel backs up.
    // ------------------------------------------------------------------------
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_wanted && !hold_served) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = 1'b1;
            end else begin
                i_out_ready <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PERCENT);
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if neither channel moves a beat for too long.
    // ------------------------------------------------------------------------
    initial begin
        int stuck_cycles;

        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("Timed out: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[rv32_subset_single_cycle_core_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        // Directed sequence. The first three seed all-ones, the largest
        // positive immediate and the most negative immediate into registers;
        // the rest then covers every operation on those extremes: SRA by 31
        // and by a shift register whose upper bits are set, ANDI with a
        // negative mask, a write to x0 that must be dropped, a store and a
        // load that wrap past the last byte of the memory, an unaligned load,
        // a load with a non-standard funct3, a taken branch with the most
        // negative offset, an untaken one with the largest offset, a branch
        // on equal operands, a jump and an odd-target jump with x0 as link, and
        // illegal words of every kind.
        directed_words = '{
            enc_i(12'hFFF, 5'd0, F3_ADD, 5'd1, OPC_ALUI),
            enc_i(12'h7FF, 5'd0, F3_ADD, 5'd2, OPC_ALUI),
            enc_i(12'h800, 5'd0, F3_ADD, 5'd10, OPC_ALUI),
            enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd11, OPC_ALU),
            enc_r(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd12, OPC_ALU),
            enc_r(F7_BASE, 5'd2, 5'd1, F3_XOR, 5'd13, OPC_ALU),
            enc_r(F7_ALT, 5'd2, 5'd10, F3_SRA, 5'd14, OPC_ALU),
            enc_r(F7_ALT, 5'd1, 5'd2, F3_SRA, 5'd15, OPC_ALU),
            enc_i(12'h0F0, 5'd1, F3_AND, 5'd3, OPC_ALUI),
            enc_i(12'hFF0, 5'd2, F3_AND, 5'd4, OPC_ALUI),
            enc_i(12'h005, 5'd1, F3_ADD, 5'd0, OPC_ALUI),
            enc_s(12'h000, 5'd10, 5'd0, F3_WORD),
            enc_s(12'hFFE, 5'd13, 5'd0, F3_WORD),
            enc_i(12'hFFE, 5'd0, F3_WORD, 5'd5, OPC_LOAD),
            enc_i(12'h001, 5'd0, F3_WORD, 5'd6, OPC_LOAD),
            enc_i(12'h7FF, 5'd1, F3_AND, 5'd11, OPC_LOAD),
            enc_b(13'h1000, 5'd2, 5'd1, F3_BLT),
            enc_b(13'h0FFE, 5'd1, 5'd2, F3_BLT),
            enc_b(13'h0008, 5'd1, 5'd1, F3_BLT),
            enc_i(12'h7FF, 5'd1, F3_ADD, 5'd7, OPC_JALR),
            enc_i(12'hFFF, 5'd13, F3_SRA, 5'd0, OPC_JALR),
            enc_r(F7_BAD, 5'd2, 5'd1, F3_ADD, 5'd8, OPC_ALU),
            enc_r(F7_ALT, 5'd2, 5'd1, F3_XOR, 5'd8, OPC_ALU),
            enc_i(12'h123, 5'd1, F3_BAD, 5'd8, OPC_ALUI),
            32'h0000_0000,
            32'hFFFF_FFFF
        };
        directed_count = directed_words.size();

        // Synchronous reset first; the core then clears its data
        // memory before it raises ready, which the sender simply waits out.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_words[i]) begin
            offer_instruction(directed_words[i]);
        end

        // Random stream with idling on both sides.
        repeat (200) begin
            offer_instruction(random_instruction());
        end

        // A stretch at full rate with no idling anywhere.
        quiet_phase = 1'b1;
        repeat (100) begin
            offer_instruction(random_instruction());
        end
        quiet_phase = 1'b0;

        // The receiver stalls for a long stretch while instructions keep
        // coming; idling resumes once the stall is over.
        hold_wanted = 1'b1;
        repeat (230) begin
            offer_instruction(random_instruction());
        end

        // One more edge so that the checker has counted the last beat
        // before the outstanding count is trusted.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Executed %0d instructions (%0d directed, the rest weighted random)",
                 sent_count, directed_count);
        $display("and compared %0d result beats, including a %0d-cycle result stall.",
                 checked_count, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("[rv32_subset_single_cycle_core_unit] OK");
        end else begin
            $display("[rv32_subset_single_cycle_core_unit] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rvcore_pkg.sv
rtl/rvcore_ram.sv
rtl/rvcore_exec.sv
rtl/rv32_subset_single_cycle_core_unit.sv
tb/core_result_checker.sv
tb/testbench.sv
